// ===== sv/hfa_pkg.sv =====
// Shared widths, stream layout and stage record types for the hex float adder.
// No dependencies; imported by hex_float_add_top.
package hfa_pkg;

  localparam int EXPO_W   = 7;
  localparam int FRACT_W  = 56;
  localparam int SHORT_W  = 24;
  localparam int WIDE_W   = FRACT_W + 4;      // fraction plus guard digit
  localparam int SUM_W    = FRACT_W + 8;      // plus carry digit
  localparam int IN_W     = 136;              // 129 field bits, byte padded
  localparam int OUT_W    = 72;               // 65 field bits, byte padded
  localparam int DIGITS_L = FRACT_W / 4;

  localparam logic [EXPO_W-1:0] EXPO_MAX = 7'h7F;

  typedef struct packed {
    logic                 is_long;
    logic                 nrm;
    logic                 pass;
    logic                 xs;
    logic [EXPO_W-1:0]    xe;
    logic [FRACT_W-1:0]   xf;
    logic                 ys;
    logic [FRACT_W-1:0]   yf;
    logic [EXPO_W-1:0]    diff;
  } s1_t;

  typedef struct packed {
    logic                 is_long;
    logic                 nrm;
    logic                 sub;
    logic                 xs;
    logic                 ys;
    logic [EXPO_W-1:0]    xe;
    logic [WIDE_W-1:0]    xw;
    logic [WIDE_W-1:0]    yw;
  } s2_t;

  typedef struct packed {
    logic                 is_long;
    logic                 nrm;
    logic                 sign;
    logic [EXPO_W-1:0]    xe;
    logic [SUM_W-1:0]     r;
  } s3_t;

  typedef struct packed {
    logic                 is_long;
    logic                 sign;
    logic                 carry;
    logic                 zero;
    logic [EXPO_W-1:0]    xe;
    logic [3:0]           lz;
    logic [WIDE_W-1:0]    w;
    logic [FRACT_W-1:0]   cf;
  } s4_t;

endpackage

// ===== sv/hex_float_add_top.sv =====
// Pipelined base-16 excess-64 floating-point adder, short and long formats.
// Depends on hfa_pkg for widths and stage record types.
//
// One add request enters per cycle while the pipeline has room and passes
// through five registered stages (decode/swap, digit align, add/subtract,
// leading-digit count, normalize shift); every stage holds its request while
// the next one is full, so a stalled output backs up stage by stage and the
// input keeps taking requests until all five stages are occupied. The align and
// normalize barrel shifters and the 61-bit add/subtract set the stage depth.
module hex_float_add_top (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    s_tvalid,
  output logic                    s_tready,
  // normalize, a_sign, a_expo, a_fract, b_sign, b_expo, b_fract, zero pad
  input  logic [hfa_pkg::IN_W-1:0]  s_tdata,
  // is_long
  input  logic                    s_tuser,
  output logic                    m_tvalid,
  input  logic                    m_tready,
  // sum_sign, sum_expo, sum_fract, exp_overflow, zero pad
  output logic [hfa_pkg::OUT_W-1:0] m_tdata
);
  import hfa_pkg::*;

  logic v1, v2, v3, v4;
  logic en1, en2, en3, en4, en5;
  s1_t s1, s1_next;
  s2_t s2, s2_next;
  s3_t s3, s3_next;
  s4_t s4, s4_next;
  logic out_long;
  logic [OUT_W-1:0] out_next;

  assign en5 = !m_tvalid || m_tready;
  assign en4 = !v4 || en5;
  assign en3 = !v3 || en4;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign s_tready = en1;

  // Stage 1: mask to format, spot zero operands, put larger exponent in x
  logic               in_nrm, a_s, b_s, a_zero, b_zero, sel_a;
  logic [EXPO_W-1:0]  a_e, b_e;
  logic [FRACT_W-1:0] a_f, b_f;

  always_comb begin
    in_nrm = s_tdata[0];
    a_s    = s_tdata[1];
    a_e    = s_tdata[8:2];
    b_s    = s_tdata[65];
    b_e    = s_tdata[72:66];
    if (s_tuser) begin
      a_f = s_tdata[64:9];
      b_f = s_tdata[128:73];
    end else begin
      a_f = {{(FRACT_W-SHORT_W){1'b0}}, s_tdata[9 +: SHORT_W]};
      b_f = {{(FRACT_W-SHORT_W){1'b0}}, s_tdata[73 +: SHORT_W]};
    end
    a_zero = (a_f == '0) && (a_e == '0);
    b_zero = (b_f == '0) && (b_e == '0);
    sel_a  = b_zero || (!a_zero && (a_e >= b_e));
    s1_next.is_long = s_tuser;
    s1_next.nrm     = in_nrm;
    s1_next.pass    = a_zero || b_zero;
    s1_next.xs      = sel_a ? a_s : b_s;
    s1_next.xe      = sel_a ? a_e : b_e;
    s1_next.xf      = sel_a ? a_f : b_f;
    s1_next.ys      = sel_a ? b_s : a_s;
    s1_next.yf      = sel_a ? b_f : a_f;
    s1_next.diff    = sel_a ? (a_e - b_e) : (b_e - a_e);
  end

  // Stage 2: shift y right by diff-1 digits; x keeps a guard digit
  logic [EXPO_W-1:0]  sh;
  logic [FRACT_W-1:0] y_shr;
  logic               shifted_away;
  logic [WIDE_W-1:0]  y_al;

  always_comb begin
    sh = s1.diff - 7'd1;
    if (s1.diff >= 7'd16) begin
      y_shr = '0;
    end else begin
      y_shr = s1.yf >> {sh[3:0], 2'b00};
    end
    shifted_away = (s1.diff >= 7'd2) && (y_shr == '0);
    if (s1.diff == '0) begin
      y_al = {s1.yf, 4'h0};
    end else if (s1.diff == 7'd1) begin
      y_al = {4'h0, s1.yf};
    end else begin
      y_al = {4'h0, y_shr};
    end
    s2_next.is_long = s1.is_long;
    s2_next.nrm     = s1.nrm;
    s2_next.xs      = s1.xs;
    s2_next.ys      = s1.ys;
    s2_next.xe      = s1.xe;
    s2_next.xw      = {s1.xf, 4'h0};
    // pass x through the adder alone
    s2_next.yw      = (s1.pass || shifted_away) ? '0 : y_al;
    s2_next.sub     = !(s1.pass || shifted_away) && (s1.xs != s1.ys);
  end

  // Stage 3: signed magnitude add
  logic [SUM_W-1:0]  add_r;
  logic [WIDE_W:0]   dxy;
  logic [WIDE_W-1:0] dyx;

  always_comb begin
    add_r = {4'h0, s2.xw} + {4'h0, s2.yw};
    dxy   = {1'b0, s2.xw} - {1'b0, s2.yw};
    dyx   = s2.yw - s2.xw;
    s3_next.is_long = s2.is_long;
    s3_next.nrm     = s2.nrm;
    s3_next.xe      = s2.xe;
    if (!s2.sub) begin
      s3_next.r    = add_r;
      s3_next.sign = s2.xs;
    end else if (dxy[WIDE_W]) begin
      s3_next.r    = {4'h0, dyx};
      s3_next.sign = s2.ys;
    end else begin
      s3_next.r    = {4'h0, dxy[WIDE_W-1:0]};
      s3_next.sign = s2.xs;
    end
  end

  // Stage 4: carry detect, window the result at the format's top digit, count zeros
  logic [WIDE_W-1:0] win;
  logic [3:0]        lz;

  always_comb begin
    if (s3.is_long) begin
      win = s3.r[WIDE_W-1:0];
      s4_next.carry = s3.r[SUM_W-1 -: 4] != 4'h0;
      s4_next.cf    = s3.r[SUM_W-1:8];
    end else begin
      win = {s3.r[SHORT_W+3:0], {(WIDE_W-SHORT_W-4){1'b0}}};
      s4_next.carry = s3.r[SHORT_W+7 -: 4] != 4'h0;
      s4_next.cf    = {{(FRACT_W-SHORT_W){1'b0}}, s3.r[SHORT_W+7:8]};
    end
    lz = 4'(DIGITS_L + 1);
    for (int i = 0; i <= DIGITS_L; i++) begin
      if (win[4*i +: 4] != 4'h0) begin
        lz = 4'(DIGITS_L - i);
      end
    end
    s4_next.is_long = s3.is_long;
    s4_next.sign    = s3.sign;
    s4_next.xe      = s3.xe;
    s4_next.w       = win;
    s4_next.lz      = s3.nrm ? lz : 4'h0;
    s4_next.zero    = s3.nrm ? (s3.r == '0) : (s3.r[SUM_W-1:4] == '0);
  end

  // Stage 5: normalize shift and exponent adjust
  logic [WIDE_W-1:0]  nv;
  logic [FRACT_W-1:0] nf;
  logic [EXPO_W:0]    e_adj;

  always_comb begin
    nv    = s4.w << {s4.lz, 2'b00};
    nf    = s4.is_long ? nv[WIDE_W-1:4]
                       : {{(FRACT_W-SHORT_W){1'b0}}, nv[WIDE_W-1 -: SHORT_W]};
    e_adj = {1'b0, s4.xe} - {4'h0, s4.lz};
    out_next = '0;
    if (s4.carry) begin
      out_next[0]   = s4.sign;
      out_next[7:1] = s4.xe + 7'd1;
      out_next[63:8] = s4.cf;
      out_next[64]  = s4.xe == EXPO_MAX;
    end else if (!s4.zero && !e_adj[EXPO_W]) begin
      out_next[0]    = s4.sign;
      out_next[7:1]  = e_adj[EXPO_W-1:0];
      out_next[63:8] = nf;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (en1) v1 <= s_tvalid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
      if (en5) m_tvalid <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) s1 <= s1_next;
    if (en2) s2 <= s2_next;
    if (en3) s3 <= s3_next;
    if (en4) s4 <= s4_next;
    if (en5) begin
      m_tdata  <= out_next;
      out_long <= s4.is_long;
    end
  end

  // top digit of the format sits at bits 63:60 in long and 31:28 in short
  a_ovf_wraps: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[64] |-> m_tdata[7:1] == '0 &&
      (out_long ? m_tdata[63:60] != 4'h0 : m_tdata[31:28] != 4'h0))
    else $error("overflow result without wrapped exponent");

  a_true_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[63:8] == '0 |-> m_tdata[7:0] == '0 && !m_tdata[64])
    else $error("zero fraction is not true zero");

  a_short_clean: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !out_long |-> m_tdata[63:8+SHORT_W] == '0)
    else $error("short result has bits above format");

endmodule
